// ===== hdl/opc_pkg.sv =====
// Package for the overlapping pattern counter: widths, codes and the queue item type.
// Used by every module of the block; depends on nothing else.
package opc_pkg;

  localparam int CHAR_W          = 8;
  localparam int PATTERN_W       = 64;
  localparam int LEN_W           = 4;
  localparam int COUNT_W         = 32;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;
  localparam logic [COUNT_W-1:0]   COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [LEN_W-1:0]     LEN_RESET    = 4'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  // One classified text byte on its way from the front to the back
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_newline;
    logic              last;
  } item_t;

endpackage

// ===== hdl/opc_front.sv =====
// Front stage of the overlapping pattern counter: accepts text bytes and classifies them.
// Depends on opc_pkg; feeds opc_queue.
module opc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] char_code
  input  logic                     in_tlast,   // end_of_text
  output logic                     push_valid,
  input  logic                     push_ready,
  output opc_pkg::item_t           push_item
);

  logic           valid_r, valid_nxt;
  opc_pkg::item_t item_r, item_nxt;

  // Take a new request when the stage is empty or drains this cycle
  assign in_tready = !valid_r || push_ready;

  // Classify the byte and hold it until the queue takes it
  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tready) begin
      valid_nxt            = in_tvalid;
      item_nxt.char_code   = in_tdata;
      item_nxt.is_newline  = (in_tdata == opc_pkg::NEWLINE_CODE);
      item_nxt.last        = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

// ===== hdl/opc_queue.sv =====
// Short queue between front and back of the overlapping pattern counter.
// Depends on opc_pkg for the item type.
module opc_queue #(
  parameter int DEPTH = opc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  opc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output opc_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  opc_pkg::item_t         slots_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/opc_back.sv =====
// Back stage of the overlapping pattern counter: sliding window, parallel compare,
// saturating count and the result register. Depends on opc_pkg; fed by opc_queue.
module opc_back #(
  parameter int MAX_PATTERN = opc_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  opc_pkg::item_t                pop_item,
  input  logic [opc_pkg::PATTERN_W-1:0] pattern_bytes,
  input  logic [opc_pkg::LEN_W-1:0]     pattern_length,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata   // [31:0] match_count
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int CW     = opc_pkg::CHAR_W;

  logic [CW-1:0]               window_r [MAX_PATTERN];
  logic [CW-1:0]               win_sh   [MAX_PATTERN];
  logic [FILL_W-1:0]           fill_r, fill_nxt, fill_inc;
  logic [opc_pkg::COUNT_W-1:0] total_r, total_nxt, total_upd;
  logic                        out_valid_r, out_valid_nxt;
  logic [opc_pkg::COUNT_W-1:0] out_data_r, out_data_nxt;
  logic [MAX_PATTERN-1:0]      hit;
  logic [opc_pkg::LEN_W-1:0]   eff_len;
  logic                        match;
  logic                        take;

  // Stall a last item only while the result register is still full
  assign pop_ready = !pop_item.last || !out_valid_r || out_tready;
  assign take      = pop_valid && pop_ready;

  // Shift the new byte in at the newest end
  always_comb begin
    win_sh[0] = pop_item.char_code;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_sh[i] = window_r[i-1];
    end
  end

  assign fill_inc = (fill_r == FILL_W'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;
  assign eff_len  = (pattern_length > opc_pkg::LEN_W'(MAX_PATTERN)) ?
                    opc_pkg::LEN_W'(MAX_PATTERN) : pattern_length;

  // Compare every candidate length in parallel, then pick the configured one
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      hit[l-1] = (fill_inc >= FILL_W'(l));
      for (int k = 0; k < l; k++) begin
        if (win_sh[l-1-k] != pattern_bytes[8*k +: 8]) begin
          hit[l-1] = 1'b0;
        end
      end
    end
    match = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (eff_len == opc_pkg::LEN_W'(l)) begin
        match = hit[l-1];
      end
    end
  end

  assign total_upd = (match && total_r != opc_pkg::COUNT_MAX) ? total_r + 1'b1 : total_r;

  // Update line state and count; emit and restart on the last byte
  always_comb begin
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (take) begin
      if (pop_item.is_newline) begin
        fill_nxt = '0;
      end else begin
        fill_nxt  = fill_inc;
        total_nxt = total_upd;
      end
      if (pop_item.last) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = total_nxt;
        fill_nxt      = '0;
        total_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    if (take && !pop_item.is_newline) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_r[i] <= win_sh[i];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/overlapping_pattern_counter.sv =====
// Overlapping pattern counter, top level: configuration registers, front, queue and back.
// Depends on opc_pkg, opc_front, opc_queue and opc_back.
// Path: a last byte accepted into the front register is written into the queue, then
// taken by the back, which counts it and raises out_tvalid from its result register.
// Throughput: one byte per cycle, set by the combinational window compare in the back;
// a last byte waits only while the previous count is still untaken.
// Reset (rst_n low, synchronous): empty pipeline and queue, zero count, empty line,
// pattern_bytes zero and pattern_length one.
module overlapping_pattern_counter #(
  parameter int MAX_PATTERN = opc_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] char_code
  input  logic                          in_tlast,   // end_of_text
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [31:0] match_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [opc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [opc_pkg::PATTERN_W-1:0] cfg_data
);

  logic [opc_pkg::PATTERN_W-1:0] pattern_bytes_r, pattern_bytes_nxt;
  logic [opc_pkg::LEN_W-1:0]     pattern_length_r, pattern_length_nxt;
  logic                          push_valid, push_ready;
  logic                          pop_valid, pop_ready;
  opc_pkg::item_t                push_item, pop_item;

  assign cfg_ready = 1'b1;

  // Decode configuration write requests
  always_comb begin
    pattern_bytes_nxt  = pattern_bytes_r;
    pattern_length_nxt = pattern_length_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        opc_pkg::REG_PATTERN_BYTES:  pattern_bytes_nxt  = cfg_data;
        opc_pkg::REG_PATTERN_LENGTH: pattern_length_nxt = cfg_data[opc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= opc_pkg::LEN_RESET;
    end else begin
      pattern_bytes_r  <= pattern_bytes_nxt;
      pattern_length_r <= pattern_length_nxt;
    end
  end

  opc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  opc_queue #(
    .DEPTH (opc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  opc_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .pattern_bytes  (pattern_bytes_r),
    .pattern_length (pattern_length_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

// ===== bench/overlapping_pattern_counter_tb.sv =====
// Testbench for overlapping_pattern_counter: directed and random byte streams against a
// built-in pattern-count predictor, with random idling on the text and count streams.
// Depends on opc_pkg and the overlapping_pattern_counter RTL.
module overlapping_pattern_counter_tb;

  localparam int MAX_PAT      = opc_pkg::MAX_PATTERN_DEF;
  localparam int RANDOM_ITEMS = 1525;
  localparam int QUIET_LIMIT  = 400;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;   // [7:0] char_code
  logic                          in_tlast   = 1'b0; // end_of_text
  logic                          out_tvalid;
  logic                          out_tready = 1'b1;
  logic [31:0]                   out_tdata;         // [31:0] match_count
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [opc_pkg::CFG_IDX_W-1:0] cfg_index  = opc_pkg::REG_PATTERN_BYTES;
  logic [opc_pkg::PATTERN_W-1:0] cfg_data   = '0;

  // Predictor state: configuration copy, line window and running stream total
  logic [opc_pkg::PATTERN_W-1:0] pat_bytes = '0;
  logic [opc_pkg::LEN_W-1:0]     pat_len   = opc_pkg::LEN_RESET;
  logic [opc_pkg::CHAR_W-1:0]    win [MAX_PAT];
  int                            line_len  = 0;
  logic [opc_pkg::COUNT_W-1:0]   run_total = '0;

  logic [opc_pkg::COUNT_W-1:0]   expected_totals [$];
  int                            mismatches   = 0;
  bit                            no_idle      = 1'b0;
  int                            hold_cycles  = 0;
  int                            quiet_cycles = 0;

  overlapping_pattern_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clear the line window and its fill level
  task automatic clear_line();
    foreach (win[i]) win[i] = '0;
    line_len = 0;
  endtask

  // Advance the predictor by one text byte; queue the total when the stream ends
  task automatic count_byte(input logic [opc_pkg::CHAR_W-1:0] ch, input logic last);
    int  eff;
    bit  hit;
    if (ch == opc_pkg::NEWLINE_CODE) begin
      clear_line();
    end else begin
      for (int i = MAX_PAT - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = ch;
      if (line_len < MAX_PAT) line_len++;
      eff = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
      hit = (eff != 0) && (line_len >= eff);
      for (int k = 0; k < eff; k++) begin
        if (win[eff-1-k] != pat_bytes[8*k +: 8]) hit = 1'b0;
      end
      if (hit && run_total != opc_pkg::COUNT_MAX) run_total++;
    end
    if (last) begin
      expected_totals.push_back(run_total);
      clear_line();
      run_total = '0;
    end
  endtask

  // Send one text byte after a random gap; valid stays high for a back-to-back byte
  task automatic send_byte(input logic [opc_pkg::CHAR_W-1:0] ch, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    count_byte(ch, last);
  endtask

  // Drop the text stream, drain all counts and let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register request; only called once the block is idle
  task automatic write_reg(input logic [opc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [opc_pkg::PATTERN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == opc_pkg::REG_PATTERN_BYTES) pat_bytes = data;
    else pat_len = data[opc_pkg::LEN_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset pattern is a single zero byte
  task automatic test_reset_values();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Overlapping "aba" matches, with a newline that must break a would-be match
  task automatic test_overlap_and_newline();
    logic [opc_pkg::CHAR_W-1:0] text [8];
    text = '{8'h61, 8'h62, opc_pkg::NEWLINE_CODE, 8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
    settle();
    write_reg(opc_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0061_6261);
    write_reg(opc_pkg::REG_PATTERN_LENGTH, 64'd3);
    foreach (text[i]) send_byte(text[i], i == 7);
  endtask

  // Newline never matches even as the pattern; zero length matches nothing
  task automatic test_newline_and_zero_length();
    settle();
    write_reg(opc_pkg::REG_PATTERN_BYTES, 64'h0A);
    write_reg(opc_pkg::REG_PATTERN_LENGTH, 64'd1);
    send_byte(opc_pkg::NEWLINE_CODE, 1'b1);
    settle();
    write_reg(opc_pkg::REG_PATTERN_BYTES, 64'h0);
    write_reg(opc_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    send_byte(8'h00, 1'b1);
  endtask

  // Length above the maximum acts as the maximum
  task automatic test_overlong_length();
    settle();
    write_reg(opc_pkg::REG_PATTERN_BYTES, {opc_pkg::PATTERN_W{1'b1}});
    write_reg(opc_pkg::REG_PATTERN_LENGTH, 64'd15);
    for (int i = 0; i < 9; i++) send_byte(8'hFF, i == 8);
  endtask

  // Change the pattern inside a stream; the window must be kept
  task automatic test_midstream_change();
    settle();
    write_reg(opc_pkg::REG_PATTERN_BYTES, 64'h6261);
    write_reg(opc_pkg::REG_PATTERN_LENGTH, 64'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    settle();
    write_reg(opc_pkg::REG_PATTERN_BYTES, 64'h61_6261);
    write_reg(opc_pkg::REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h61, 1'b1);
  endtask

  // Random phases: new settings, then streams built mostly from pattern pieces
  task automatic test_random_text();
    int                         sent;
    int                         eff;
    int                         n;
    int                         pick;
    int                         pos;
    bit                         first;
    bit                         close;
    logic [3:0]                 len_sel;
    logic [opc_pkg::CHAR_W-1:0] text [$];
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if (first || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(opc_pkg::REG_PATTERN_BYTES, {opc_pkg::PATTERN_W{1'b1}});
          1:       write_reg(opc_pkg::REG_PATTERN_BYTES, '0);
          default: write_reg(opc_pkg::REG_PATTERN_BYTES, {$urandom, $urandom});
        endcase
      end
      if (first || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       len_sel = 4'd0;
          1:       len_sel = 4'd1;
          2:       len_sel = 4'd8;
          3:       len_sel = 4'($urandom_range(9, 15));
          default: len_sel = 4'($urandom_range(1, 8));
        endcase
        write_reg(opc_pkg::REG_PATTERN_LENGTH, {$urandom, 28'($urandom), len_sel});
      end
      first   = 1'b0;
      no_idle = ($urandom_range(0, 3) == 0);
      eff     = (pat_len == 0 || pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
      for (int s = $urandom_range(1, 4); s > 0; s--) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        text.delete();
        while (text.size() < n) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            // whole pattern copy, sometimes with one byte spoiled
            for (int k = 0; k < eff; k++) text.push_back(pat_bytes[8*k +: 8]);
            if ($urandom_range(0, 3) == 0) begin
              pos = text.size() - 1 - $urandom_range(0, eff - 1);
              text[pos] = 8'($urandom_range(0, 255));
            end
          end else if (pick < 70) begin
            pos = $urandom_range(0, eff - 1);
            text.push_back(pat_bytes[8*pos +: 8]);
          end else if (pick < 80) begin
            text.push_back(opc_pkg::NEWLINE_CODE);
          end else begin
            text.push_back(8'($urandom_range(0, 255)));
          end
        end
        // leave the last stream of a phase open now and then
        close = (s > 1) || ($urandom_range(0, 3) != 0);
        foreach (text[i]) begin
          send_byte(text[i], close && (i == text.size() - 1));
          sent++;
        end
      end
    end
    // close whatever stream is still open
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Take counts with random stalls and check each against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_totals.size() == 0) begin
        $error("match_count: none expected, got %0d", out_tdata);
        mismatches++;
      end else begin
        if (out_tdata !== expected_totals[0]) begin
          $error("match_count: expected %0d, got %0d", expected_totals[0], out_tdata);
          mismatches++;
        end
        void'(expected_totals.pop_front());
      end
      hold_cycles = no_idle ? 0 : $urandom_range(0, 13);
      if (hold_cycles != 0) out_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles--;
      if (hold_cycles == 0) out_tready <= 1'b1;
    end
  end

  // End the run when no request moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[overlapping_pattern_counter] ERROR");
        $finish;
      end
    end
  end

  initial begin
    clear_line();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_overlap_and_newline();
    test_newline_and_zero_length();
    test_overlong_length();
    test_midstream_change();
    test_random_text();
    in_tvalid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[overlapping_pattern_counter] OK");
    end else begin
      $display("[overlapping_pattern_counter] ERROR");
    end
    $finish;
  end

endmodule

// ===== overlapping_pattern_counter.f =====
hdl/opc_pkg.sv
hdl/opc_front.sv
hdl/opc_queue.sv
hdl/opc_back.sv
hdl/overlapping_pattern_counter.sv
bench/overlapping_pattern_counter_tb.sv
